// ----- design/drg_pkg.sv -----
// Shared types and constants for the dynamic resolution governor.
`timescale 1ns / 1ps
package drg_pkg;

    localparam int COUNTER_BITS = 8;
    localparam int CMP_W        = 16;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    localparam logic [15:0] FULL_SCALE = 16'd32768;
    localparam logic [15:0] MIN_FLOOR  = 16'd8192;
    localparam logic [15:0] KEEP_Q16   = 16'd58982;
    localparam logic [15:0] ALPHA_Q16  = 16'd6554;
    localparam logic [15:0] K095_Q16   = 16'd62259;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = 64;
    localparam int DIVD_W  = 64;
    localparam int DIVS_W  = 32;

    localparam logic [3:0] REG_TARGET_TIME = 4'd0;
    localparam logic [3:0] REG_SCALE_FLOOR = 4'd1;
    localparam logic [3:0] REG_STEP_SIZE   = 4'd2;
    localparam logic [3:0] REG_OVERSHOOT   = 4'd3;
    localparam logic [3:0] REG_HEADROOM    = 4'd4;
    localparam logic [3:0] REG_DOWN_FRAMES = 4'd5;
    localparam logic [3:0] REG_UP_FRAMES   = 4'd6;
    localparam logic [3:0] REG_COOLDOWN    = 4'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_EMA2, ST_EMA3, ST_COOL, ST_OVER,
        ST_F1, ST_F2, ST_F3, ST_F4, ST_FDIV, ST_FSQ_GO, ST_FSQ, ST_FD2_GO, ST_FD2,
        ST_FMUL, ST_CLAMP, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
        ST_SNAP, ST_SDIV, ST_SMUL, ST_COMMIT, ST_DONE
    } drg_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD_IN, OP_EMA_INIT, OP_MUL_EMA, OP_MUL_X, OP_EMA_UPD,
        OP_COOL_DEC, OP_MUL_OVT, OP_OVER_FLOOR, OP_OVER_INC, OP_NOT_OVER,
        OP_MUL_SS, OP_MUL_PT, OP_MUL_PK, OP_DIV_FIT, OP_SQRT, OP_DIV_STEP,
        OP_MUL_QS, OP_CLAMP, OP_MUL_PR, OP_MUL_TH, OP_MUL_PC, OP_HEAD,
        OP_DIV_SNAP, OP_COMMIT, OP_LOAD_OUT
    } drg_op_t;

    typedef struct packed {
        logic in_zero;
        logic ema_zero;
        logic cool_nz;
        logic over_hit;
        logic at_floor;
        logic over_reached;
        logic can_raise;
        logic head_ok;
        logic under_reached;
        logic div_done;
        logic sqrt_done;
    } drg_status_t;

endpackage

// ----- design/drg_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module drg_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [drg_pkg::DIVD_W-1:0] dividend,
    input  logic [drg_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [drg_pkg::DIVD_W-1:0] quotient
);
    localparam int CW = $clog2(drg_pkg::DIVD_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [drg_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [drg_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic [drg_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [drg_pkg::DIVS_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[drg_pkg::DIVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = drg_pkg::DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[drg_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[drg_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[drg_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(drg_pkg::DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- design/drg_sqrt.sv -----
// Integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module drg_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [drg_pkg::DIVD_W-1:0] radicand,
    output logic                       done,
    output logic [31:0]                root
);
    localparam int W  = drg_pkg::DIVD_W;
    localparam int CW = $clog2(W / 2);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  v_reg, v_next;
    logic [W-1:0]  res_reg, res_next;
    logic [W-1:0]  bit_reg, bit_next;
    logic [W-1:0]  trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = radicand;
            res_next  = '0;
            bit_next  = W'(1) << (W - 2);
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W / 2 - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];
endmodule

// ----- design/drg_ctrl.sv -----
// Sequencer that walks the datapath through one frame sample.
`timescale 1ns / 1ps
module drg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  drg_pkg::drg_status_t status,
    output drg_pkg::drg_op_t     op
);
    drg_pkg::drg_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drg_pkg::ST_IDLE:   if (s_valid) state_next = drg_pkg::ST_CHK;
            drg_pkg::ST_CHK: begin
                if (status.in_zero)       state_next = drg_pkg::ST_DONE;
                else if (status.ema_zero) state_next = drg_pkg::ST_COOL;
                else                      state_next = drg_pkg::ST_EMA2;
            end
            drg_pkg::ST_EMA2:   state_next = drg_pkg::ST_EMA3;
            drg_pkg::ST_EMA3:   state_next = drg_pkg::ST_COOL;
            drg_pkg::ST_COOL:
                state_next = status.cool_nz ? drg_pkg::ST_DONE : drg_pkg::ST_OVER;
            drg_pkg::ST_OVER: begin
                if (status.over_hit) begin
                    if (!status.at_floor && status.over_reached) state_next = drg_pkg::ST_F1;
                    else                                          state_next = drg_pkg::ST_DONE;
                end else begin
                    state_next = status.can_raise ? drg_pkg::ST_H2 : drg_pkg::ST_DONE;
                end
            end
            drg_pkg::ST_F1:     state_next = drg_pkg::ST_F2;
            drg_pkg::ST_F2:     state_next = drg_pkg::ST_F3;
            drg_pkg::ST_F3:     state_next = drg_pkg::ST_F4;
            drg_pkg::ST_F4:     state_next = drg_pkg::ST_FDIV;
            drg_pkg::ST_FDIV:   if (status.div_done) state_next = drg_pkg::ST_FSQ_GO;
            drg_pkg::ST_FSQ_GO: state_next = drg_pkg::ST_FSQ;
            drg_pkg::ST_FSQ:    if (status.sqrt_done) state_next = drg_pkg::ST_FD2_GO;
            drg_pkg::ST_FD2_GO: state_next = drg_pkg::ST_FD2;
            drg_pkg::ST_FD2:    if (status.div_done) state_next = drg_pkg::ST_FMUL;
            drg_pkg::ST_FMUL:   state_next = drg_pkg::ST_CLAMP;
            drg_pkg::ST_CLAMP:  state_next = drg_pkg::ST_SNAP;
            drg_pkg::ST_H2:     state_next = drg_pkg::ST_H3;
            drg_pkg::ST_H3:     state_next = drg_pkg::ST_H4;
            drg_pkg::ST_H4:     state_next = drg_pkg::ST_H5;
            drg_pkg::ST_H5:     state_next = drg_pkg::ST_H6;
            drg_pkg::ST_H6: begin
                if (status.head_ok && status.under_reached) state_next = drg_pkg::ST_SNAP;
                else                                         state_next = drg_pkg::ST_DONE;
            end
            drg_pkg::ST_SNAP:   state_next = drg_pkg::ST_SDIV;
            drg_pkg::ST_SDIV:   if (status.div_done) state_next = drg_pkg::ST_SMUL;
            drg_pkg::ST_SMUL:   state_next = drg_pkg::ST_COMMIT;
            drg_pkg::ST_COMMIT: state_next = drg_pkg::ST_DONE;
            drg_pkg::ST_DONE:   if (out_free) state_next = drg_pkg::ST_IDLE;
            default:            state_next = drg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        op           = drg_pkg::OP_NONE;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            drg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) op = drg_pkg::OP_LOAD_IN;
            end
            drg_pkg::ST_CHK: begin
                if (status.in_zero)       op = drg_pkg::OP_NONE;
                else if (status.ema_zero) op = drg_pkg::OP_EMA_INIT;
                else                      op = drg_pkg::OP_MUL_EMA;
            end
            drg_pkg::ST_EMA2:   op = drg_pkg::OP_MUL_X;
            drg_pkg::ST_EMA3:   op = drg_pkg::OP_EMA_UPD;
            drg_pkg::ST_COOL:
                op = status.cool_nz ? drg_pkg::OP_COOL_DEC : drg_pkg::OP_MUL_OVT;
            drg_pkg::ST_OVER: begin
                if (status.over_hit)
                    op = status.at_floor ? drg_pkg::OP_OVER_FLOOR : drg_pkg::OP_OVER_INC;
                else
                    op = drg_pkg::OP_NOT_OVER;
            end
            drg_pkg::ST_F1:     op = drg_pkg::OP_MUL_SS;
            drg_pkg::ST_F2:     op = drg_pkg::OP_MUL_PT;
            drg_pkg::ST_F3:     op = drg_pkg::OP_MUL_PK;
            drg_pkg::ST_F4:     op = drg_pkg::OP_DIV_FIT;
            drg_pkg::ST_FSQ_GO: op = drg_pkg::OP_SQRT;
            drg_pkg::ST_FD2_GO: op = drg_pkg::OP_DIV_STEP;
            drg_pkg::ST_FMUL:   op = drg_pkg::OP_MUL_QS;
            drg_pkg::ST_CLAMP:  op = drg_pkg::OP_CLAMP;
            drg_pkg::ST_H2:     op = drg_pkg::OP_MUL_PR;
            drg_pkg::ST_H3:     op = drg_pkg::OP_MUL_TH;
            drg_pkg::ST_H4:     op = drg_pkg::OP_MUL_PC;
            drg_pkg::ST_H5:     op = drg_pkg::OP_MUL_PC;
            drg_pkg::ST_H6:     op = drg_pkg::OP_HEAD;
            drg_pkg::ST_SNAP:   op = drg_pkg::OP_DIV_SNAP;
            drg_pkg::ST_SMUL:   op = drg_pkg::OP_MUL_QS;
            drg_pkg::ST_COMMIT: op = drg_pkg::OP_COMMIT;
            drg_pkg::ST_DONE: begin
                if (out_free) begin
                    op           = drg_pkg::OP_LOAD_OUT;
                    m_valid_next = 1'b1;
                end
            end
            default:            op = drg_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

// ----- design/drg_dp.sv -----
// Datapath: config, governor state, shared multiplier, divider and root units.
`timescale 1ns / 1ps
module drg_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [15:0]          s_gpu_time,
    input  drg_pkg::drg_op_t     op,
    output drg_pkg::drg_status_t status,
    output logic                 m_scale_changed,
    output logic [15:0]          m_scale
);
    localparam int CB = drg_pkg::COUNTER_BITS;

    // configuration
    logic [15:0] target_reg, floor_cfg_reg;
    logic [14:0] step_reg;
    logic [9:0]  ovt_reg;
    logic [8:0]  hr_reg;
    logic [7:0]  down_reg, up_reg, cool_cfg_reg;

    // governor state
    logic [23:0]   ema_reg, ema_next;
    logic [15:0]   cs_reg, cs_next;
    logic [CB-1:0] over_reg, over_next;
    logic [CB-1:0] under_reg, under_next;
    logic [7:0]    cool_reg, cool_next;
    logic          chg_reg, chg_next;

    // scratch
    logic [15:0]                t_reg, t_next;
    logic [drg_pkg::PROD_W-1:0] p_reg, p_next;
    logic [drg_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [16:0]                v_reg, v_next;
    logic                       out_chg_reg;
    logic [15:0]                out_scale_reg;

    logic [drg_pkg::MUL_A_W-1:0] mul_a;
    logic [drg_pkg::MUL_B_W-1:0] mul_b;

    logic                       div_start, sq_start, div_done, sq_done;
    logic [drg_pkg::DIVD_W-1:0] div_dvd, quo;
    logic [drg_pkg::DIVS_W-1:0] div_dvs;
    logic [31:0]                root;

    logic [14:0]   st;
    logic [15:0]   floor_s;
    logic [16:0]   raised_sum;
    logic [15:0]   raised;
    logic [23:0]   x;
    logic [CB-1:0] over_inc, under_inc;
    logic [40:0]   ema_sum;
    logic [16:0]   c1, c2, c3;
    logic          hi_neg;
    logic [15:0]   hi;
    logic [15:0]   snapped;

    assign st         = (step_reg == '0) ? 15'd1 : step_reg;
    assign floor_s    = (floor_cfg_reg < drg_pkg::MIN_FLOOR) ? drg_pkg::MIN_FLOOR :
                        ((floor_cfg_reg > drg_pkg::FULL_SCALE) ? drg_pkg::FULL_SCALE
                                                               : floor_cfg_reg);
    assign raised_sum = {1'b0, cs_reg} + 17'(st);
    assign raised     = (raised_sum > 17'(drg_pkg::FULL_SCALE)) ? drg_pkg::FULL_SCALE
                                                                 : raised_sum[15:0];
    assign x          = {t_reg, 8'd0};
    assign over_inc   = (over_reg == drg_pkg::CNT_MAX) ? over_reg : over_reg + 1'b1;
    assign under_inc  = (under_reg == drg_pkg::CNT_MAX) ? under_reg : under_reg + 1'b1;
    assign ema_sum    = 41'(acc_reg) + 41'(p_reg) + 41'd32768;

    assign hi_neg = 16'(st) > cs_reg;
    assign hi     = cs_reg - 16'(st);
    assign c1     = (p_reg > drg_pkg::PROD_W'(65536)) ? 17'd65536 : p_reg[16:0];
    assign c2     = (c1 > 17'(hi)) ? 17'(hi) : c1;
    assign c3     = (hi_neg || c2 < 17'(floor_s)) ? 17'(floor_s) : c2;

    // saturate, then a zero result takes one step
    assign snapped = (p_reg > drg_pkg::PROD_W'(drg_pkg::FULL_SCALE)) ? drg_pkg::FULL_SCALE :
                     ((p_reg == '0) ? 16'(st) : p_reg[15:0]);

    always_comb begin
        status.in_zero       = (t_reg == '0) || (target_reg == '0);
        status.ema_zero      = (ema_reg == '0);
        status.cool_nz       = (cool_reg != '0);
        status.over_hit      = drg_pkg::PROD_W'(ema_reg) > p_reg;
        status.at_floor      = (cs_reg <= floor_s);
        status.over_reached  = drg_pkg::CMP_W'(over_inc) >= drg_pkg::CMP_W'(down_reg);
        status.can_raise     = (raised > cs_reg) && (cs_reg != '0);
        status.head_ok       = acc_reg < p_reg;
        status.under_reached = drg_pkg::CMP_W'(under_inc) >= drg_pkg::CMP_W'(up_reg);
        status.div_done      = div_done;
        status.sqrt_done     = sq_done;
    end

    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        t_next     = t_reg;
        acc_next   = acc_reg;
        v_next     = v_reg;
        ema_next   = ema_reg;
        cs_next    = cs_reg;
        over_next  = over_reg;
        under_next = under_reg;
        cool_next  = cool_reg;
        chg_next   = chg_reg;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        case (op)
            drg_pkg::OP_LOAD_IN: begin
                t_next   = s_gpu_time;
                chg_next = 1'b0;
            end
            drg_pkg::OP_EMA_INIT: ema_next = x;
            drg_pkg::OP_MUL_EMA: begin
                mul_a = drg_pkg::MUL_A_W'(ema_reg);
                mul_b = drg_pkg::KEEP_Q16;
            end
            drg_pkg::OP_MUL_X: begin
                acc_next = p_reg;
                mul_a    = drg_pkg::MUL_A_W'(x);
                mul_b    = drg_pkg::ALPHA_Q16;
            end
            drg_pkg::OP_EMA_UPD: ema_next = ema_sum[39:16];
            drg_pkg::OP_COOL_DEC: cool_next = cool_reg - 1'b1;
            drg_pkg::OP_MUL_OVT: begin
                mul_a = drg_pkg::MUL_A_W'(target_reg);
                mul_b = drg_pkg::MUL_B_W'(ovt_reg);
            end
            drg_pkg::OP_OVER_FLOOR: begin
                under_next = '0;
                over_next  = '0;
            end
            drg_pkg::OP_OVER_INC: begin
                under_next = '0;
                over_next  = over_inc;
            end
            drg_pkg::OP_NOT_OVER: begin
                over_next = '0;
                if (!status.can_raise) under_next = '0;
                mul_a = drg_pkg::MUL_A_W'(ema_reg);
                mul_b = raised;
            end
            drg_pkg::OP_MUL_SS: begin
                mul_a = drg_pkg::MUL_A_W'(cs_reg);
                mul_b = cs_reg;
            end
            drg_pkg::OP_MUL_PT: begin
                mul_a = p_reg[drg_pkg::MUL_A_W-1:0];
                mul_b = target_reg;
            end
            drg_pkg::OP_MUL_PK: begin
                mul_a = p_reg[drg_pkg::MUL_A_W-1:0];
                mul_b = drg_pkg::K095_Q16;
            end
            drg_pkg::OP_DIV_FIT: begin
                div_start = 1'b1;
                div_dvd   = p_reg;
                div_dvs   = {ema_reg, 8'd0};
            end
            drg_pkg::OP_SQRT: sq_start = 1'b1;
            drg_pkg::OP_DIV_STEP: begin
                div_start = 1'b1;
                div_dvd   = drg_pkg::DIVD_W'(root);
                div_dvs   = drg_pkg::DIVS_W'(st);
            end
            drg_pkg::OP_MUL_QS: begin
                mul_a = quo[drg_pkg::MUL_A_W-1:0];
                mul_b = drg_pkg::MUL_B_W'(st);
            end
            drg_pkg::OP_CLAMP: v_next = c3;
            drg_pkg::OP_MUL_PR: begin
                mul_a = p_reg[drg_pkg::MUL_A_W-1:0];
                mul_b = raised;
            end
            drg_pkg::OP_MUL_TH: begin
                acc_next = p_reg;
                mul_a    = drg_pkg::MUL_A_W'(target_reg);
                mul_b    = drg_pkg::MUL_B_W'(hr_reg);
            end
            drg_pkg::OP_MUL_PC: begin
                mul_a = p_reg[drg_pkg::MUL_A_W-1:0];
                mul_b = cs_reg;
            end
            drg_pkg::OP_HEAD: begin
                if (status.head_ok) begin
                    under_next = under_inc;
                    v_next     = 17'(raised);
                end else begin
                    under_next = '0;
                end
            end
            drg_pkg::OP_DIV_SNAP: begin
                div_start = 1'b1;
                div_dvd   = drg_pkg::DIVD_W'({v_reg, 1'b0}) + drg_pkg::DIVD_W'(st);
                div_dvs   = drg_pkg::DIVS_W'({st, 1'b0});
            end
            drg_pkg::OP_COMMIT: begin
                over_next  = '0;
                under_next = '0;
                if (snapped != cs_reg) begin
                    cs_next   = snapped;
                    ema_next  = '0;
                    cool_next = cool_cfg_reg;
                    chg_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        p_next = drg_pkg::PROD_W'(mul_a) * drg_pkg::PROD_W'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= 16'd4267;
            floor_cfg_reg <= 16'd16384;
            step_reg      <= 15'd1638;
            ovt_reg       <= 10'd269;
            hr_reg        <= 9'd230;
            down_reg      <= 8'd3;
            up_reg        <= 8'd30;
            cool_cfg_reg  <= 8'd10;
            ema_reg       <= '0;
            cs_reg        <= drg_pkg::FULL_SCALE;
            over_reg      <= '0;
            under_reg     <= '0;
            cool_reg      <= '0;
            chg_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    drg_pkg::REG_TARGET_TIME: target_reg    <= cfg_data;
                    drg_pkg::REG_SCALE_FLOOR: floor_cfg_reg <= cfg_data;
                    drg_pkg::REG_STEP_SIZE:   step_reg      <= cfg_data[14:0];
                    drg_pkg::REG_OVERSHOOT:   ovt_reg       <= cfg_data[9:0];
                    drg_pkg::REG_HEADROOM:    hr_reg        <= cfg_data[8:0];
                    drg_pkg::REG_DOWN_FRAMES: down_reg      <= cfg_data[7:0];
                    drg_pkg::REG_UP_FRAMES:   up_reg        <= cfg_data[7:0];
                    drg_pkg::REG_COOLDOWN:    cool_cfg_reg  <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            ema_reg   <= ema_next;
            cs_reg    <= cs_next;
            over_reg  <= over_next;
            under_reg <= under_next;
            cool_reg  <= cool_next;
            chg_reg   <= chg_next;
        end
        t_reg   <= t_next;
        p_reg   <= p_next;
        acc_reg <= acc_next;
        v_reg   <= v_next;
        if (op == drg_pkg::OP_LOAD_OUT) begin
            out_chg_reg   <= chg_reg;
            out_scale_reg <= cs_reg;
        end
    end

    drg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quo)
    );

    drg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (quo),
        .done     (sq_done),
        .root     (root)
    );

    assign m_scale_changed = out_chg_reg;
    assign m_scale         = out_scale_reg;
endmodule

// ----- design/dynamic_resolution_governor.sv -----
// Top level of the dynamic resolution governor.
//  channel | ports                         | payload
//  input   | s_valid / s_ready             | s_gpu_time (Q8.8 ms)
//  result  | m_valid / m_ready             | m_scale_changed, m_scale (Q1.15)
//  config  | cfg_wr_en, cfg_index          | cfg_data
// One request at a time. A step down makes three passes through the shared
// 64-step divider and one through the 32-step root; a step up makes one pass.
// Synchronous active-low reset restores the register defaults and full scale.
// A new request is taken while the previous result waits on m_ready; the
// next result is held in its last state until the output register frees.
`timescale 1ns / 1ps
module dynamic_resolution_governor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_gpu_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scale_changed,
    output logic [15:0] m_scale
);
    drg_pkg::drg_status_t status;
    drg_pkg::drg_op_t     op;

    drg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    drg_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_gpu_time      (s_gpu_time),
        .op              (op),
        .status          (status),
        .m_scale_changed (m_scale_changed),
        .m_scale         (m_scale)
    );
endmodule

// ----- design/drg_checker.sv -----
// Port-level checks for the governor, bound to the top level.
`timescale 1ns / 1ps
module drg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_scale_changed,
    input logic [15:0] m_scale
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scale) && $stable(m_scale_changed))
        else $error("result changed while stalled");

    a_scale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_scale <= 16'd32768) && (m_scale != 16'd0))
        else $error("scale out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");
endmodule

bind dynamic_resolution_governor drg_checker u_drg_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_scale_changed (m_scale_changed),
    .m_scale         (m_scale)
);

// ----- test/tb_dynamic_resolution_governor.sv -----
// Self-checking testbench for the dynamic resolution governor.
`timescale 1ns / 1ps
module tb_dynamic_resolution_governor;

    localparam int CNT_TOP = (1 << drg_pkg::COUNTER_BITS) - 1;

    typedef struct packed {
        logic        changed;
        logic [15:0] scale;
    } scale_result_t;

    // Governor state and registers, mirrored in the scoreboard.
    class scale_scoreboard;
        logic [15:0] target_time, floor_cfg, overshoot_f, down_n, up_n, cool_n;
        logic [14:0] step_size;
        logic [8:0]  headroom_f;
        logic [31:0] ema, cur_scale, over_cnt, under_cnt, cool_left;
        scale_result_t pending[$];
        int mismatches;

        function void reset_state();
            target_time = 4267; floor_cfg = 16384; step_size = 1638;
            overshoot_f = 269; headroom_f = 230; down_n = 3; up_n = 30; cool_n = 10;
            ema = 0; cur_scale = 32768; over_cnt = 0; under_cnt = 0; cool_left = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [15:0] val);
            case (idx)
                drg_pkg::REG_TARGET_TIME: target_time = val;
                drg_pkg::REG_SCALE_FLOOR: floor_cfg = val;
                drg_pkg::REG_STEP_SIZE:   step_size = val[14:0];
                drg_pkg::REG_OVERSHOOT:   overshoot_f = val[9:0];
                drg_pkg::REG_HEADROOM:    headroom_f = val[8:0];
                drg_pkg::REG_DOWN_FRAMES: down_n = val[7:0];
                drg_pkg::REG_UP_FRAMES:   up_n = val[7:0];
                drg_pkg::REG_COOLDOWN:    cool_n = val[7:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic snap_commit(longint unsigned v, longint unsigned st);
            longint unsigned sn;
            sn = ((2 * v + st) / (2 * st)) * st;
            if (sn > 32768) sn = 32768;
            if (sn == 0) sn = st;
            over_cnt = 0;
            under_cnt = 0;
            if (sn == cur_scale) return 1'b0;
            cur_scale = sn;
            ema = 0;
            cool_left = cool_n;
            return 1'b1;
        endfunction

        function logic govern(logic [15:0] t);
            longint unsigned st, fl, e, s, fit, nxt, raised, lhs, rhs;
            longint signed hi, cand;
            st = (step_size == 0) ? 1 : step_size;
            if (t == 0 || target_time == 0) return 1'b0;
            if (ema == 0) ema = t << 8;
            else ema = (longint'(ema) * 58982 + (longint'(t) << 8) * 6554 + 32768) >> 16;
            if (cool_left > 0) begin
                cool_left--;
                return 1'b0;
            end
            fl = (floor_cfg < 8192) ? 8192 : (floor_cfg > 32768 ? 32768 : floor_cfg);
            e = ema;
            if (e > longint'(target_time) * overshoot_f) begin
                s = cur_scale;
                under_cnt = 0;
                if (cur_scale <= fl) begin
                    over_cnt = 0;
                    return 1'b0;
                end
                over_cnt = (over_cnt >= CNT_TOP) ? CNT_TOP : over_cnt + 1;
                if (over_cnt < down_n) return 1'b0;
                fit = int_sqrt((s * s * target_time * 62259) / (256 * e));
                nxt = (fit / st) * st;
                hi = longint'(cur_scale) - longint'(st);
                cand = (nxt > 65536) ? 65536 : nxt;
                if (cand > hi) cand = hi;
                if (cand < longint'(fl)) cand = fl;
                return snap_commit(cand, st);
            end
            over_cnt = 0;
            raised = cur_scale + st;
            if (raised > 32768) raised = 32768;
            if (raised > cur_scale && cur_scale != 0) begin
                lhs = e * raised * raised;
                rhs = longint'(target_time) * headroom_f * cur_scale * cur_scale;
                if (lhs < rhs) begin
                    under_cnt = (under_cnt >= CNT_TOP) ? CNT_TOP : under_cnt + 1;
                    if (under_cnt >= up_n) return snap_commit(raised, st);
                    return 1'b0;
                end
            end
            under_cnt = 0;
            return 1'b0;
        endfunction

        function void note_frame(logic [15:0] t);
            scale_result_t r;
            r.changed = govern(t);
            r.scale = cur_scale[15:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic chg, logic [15:0] sc);
            scale_result_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result chg=%0d scale=%0d", chg, sc);
                return;
            end
            exp_r = pending.pop_front();
            if (chg !== exp_r.changed || sc !== exp_r.scale) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected chg=%0d scale=%0d, got chg=%0d scale=%0d",
                             exp_r.changed, exp_r.scale, chg, sc);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [3:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_gpu_time = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_scale_changed;
    logic [15:0] m_scale;
    bit          quiet_tail = 0;
    scale_scoreboard sb;

    dynamic_resolution_governor u_dut (.*);

    always #5 aclk = ~aclk;

    // Result side: random stall bursts, checking at the rising edge.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_scale_changed, m_scale);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_frame(s_gpu_time);
    end

    task automatic send_frame(logic [15:0] t);
        if (!quiet_tail && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 14)) @(negedge aclk);
        s_valid <= 1'b1;
        s_gpu_time <= t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 1'b0;
        // the block is busy after taking a request, so this costs nothing
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    // Frame time, mostly near the target so both step-down and step-up paths fire, else random or zero.
    function automatic logic [15:0] frame_near(logic [15:0] tgt);
        int unsigned lo, hi;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'd0;
            default: begin
                lo = tgt / 2;
                hi = tgt * 2;
                if (hi > 65535) hi = 65535;
                if (lo == 0) lo = 1;
                return 16'($urandom_range(lo, hi));
            end
        endcase
    endfunction

    initial begin
        logic [15:0] tgt;
        sb = new();
        sb.reset_state();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, zero time, zero target, unused index
        send_frame(16'd0);
        send_frame(16'hFFFF);
        send_frame(16'h0001);
        for (int i = 0; i < 6; i++) send_frame(16'hFFFF);
        drain();
        write_reg(drg_pkg::REG_TARGET_TIME, 16'd0);
        write_reg(4'd9, 16'hFFFF);
        write_reg(4'd15, 16'h0000);
        send_frame(16'd1000);
        drain();
        write_reg(drg_pkg::REG_TARGET_TIME, 16'hFFFF);
        write_reg(drg_pkg::REG_SCALE_FLOOR, 16'd0);
        write_reg(drg_pkg::REG_STEP_SIZE, 16'd0);
        write_reg(drg_pkg::REG_OVERSHOOT, 16'd256);
        write_reg(drg_pkg::REG_HEADROOM, 16'd256);
        write_reg(drg_pkg::REG_DOWN_FRAMES, 16'd0);
        write_reg(drg_pkg::REG_UP_FRAMES, 16'd0);
        write_reg(drg_pkg::REG_COOLDOWN, 16'd0);
        for (int i = 0; i < 5; i++) send_frame(16'd1);
        drain();
        write_reg(drg_pkg::REG_TARGET_TIME, 16'd256);
        write_reg(drg_pkg::REG_STEP_SIZE, 16'h7FFF);
        write_reg(drg_pkg::REG_SCALE_FLOOR, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_frame(16'hFFFF);
        drain();
        write_reg(drg_pkg::REG_SCALE_FLOOR, 16'd0);
        for (int i = 0; i < 4; i++) send_frame(16'hFFFF);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 12; ph++) begin
            tgt = (ph == 11) ? 16'hFFFF : 16'($urandom_range(1, 16000));
            write_reg(drg_pkg::REG_TARGET_TIME, tgt);
            write_reg(drg_pkg::REG_SCALE_FLOOR, 16'($urandom_range(0, 32768)));
            write_reg(drg_pkg::REG_STEP_SIZE, (ph % 4 == 0) ? 16'($urandom_range(0, 32767))
                                                            : 16'($urandom_range(1, 4096)));
            write_reg(drg_pkg::REG_OVERSHOOT, 16'($urandom_range(256, 1023)));
            write_reg(drg_pkg::REG_HEADROOM,
                      (ph == 0) ? 16'd511 : 16'($urandom_range(128, 256)));
            write_reg(drg_pkg::REG_DOWN_FRAMES,
                      16'($urandom_range(0, (ph == 1) ? 255 : 6)));
            write_reg(drg_pkg::REG_UP_FRAMES, 16'($urandom_range(0, (ph == 2) ? 255 : 8)));
            write_reg(drg_pkg::REG_COOLDOWN, 16'($urandom_range(0, (ph == 3) ? 255 : 5)));
            if (ph == 11) quiet_tail = 1;
            for (int i = 0; i < 54; i++) send_frame(frame_near(tgt));
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("dynamic_resolution_governor regression: pass");
        end else begin
            $display("dynamic_resolution_governor regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("dynamic_resolution_governor regression: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
design/drg_pkg.sv
design/drg_div.sv
design/drg_sqrt.sv
design/drg_ctrl.sv
design/drg_dp.sv
design/dynamic_resolution_governor.sv
design/drg_checker.sv
test/tb_dynamic_resolution_governor.sv
